>>> rtl/core/setr_pkg.sv
// Shared types, constants and stream layouts of the scheduler event trace recorder.
// No dependencies; used by every file of the block.
package setr_pkg;

  localparam int unsigned BUF_WORDS_DEF = 8192;
  localparam int unsigned NAME_SETS_DEF = 256;
  localparam int unsigned NAME_WAYS_DEF = 2;

  localparam int unsigned PID_W    = 22;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned COOKIE_W = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned MARGIN_W = 14;

  localparam logic [2:0] REC_WORDS = 3'd6;

  localparam logic [MARGIN_W-1:0] CAPTURE_MARGIN_RST = 14'd100;
  localparam logic [MARGIN_W-1:0] IDLE_MARGIN_RST    = 14'd48;

  localparam logic [WORD_W-1:0] TYPE_SWITCH   = 64'd1;
  localparam logic [WORD_W-1:0] TYPE_FREE     = 64'd2;
  localparam logic [WORD_W-1:0] TYPE_OVERFLOW = '1;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_IOWAIT  = 2'd1;
  localparam logic [1:0] ST_SLEEP   = 2'd2;

  // input tdata layout
  localparam int unsigned I_TS_LSB     = 0;
  localparam int unsigned I_PID_LSB    = 64;
  localparam int unsigned I_TGID_LSB   = 86;
  localparam int unsigned I_COOKIE_LSB = 108;
  localparam int unsigned I_RUN_BIT    = 140;
  localparam int unsigned I_IOW_BIT    = 141;
  localparam int unsigned I_HASH_LSB   = 142;
  localparam int unsigned I_OK_BIT     = 174;
  localparam int unsigned IN_TDATA_W   = 176;

  // output tdata layout
  localparam int unsigned O_SEL_BIT    = 0;
  localparam int unsigned O_ADDR_LSB   = 1;
  localparam int unsigned O_WORD_LSB   = 14;
  localparam int unsigned O_NPID_LSB   = 78;
  localparam int unsigned O_COUNT_LSB  = 100;
  localparam int unsigned O_PAD_W      = 6;
  localparam int unsigned OUT_TDATA_W  = 120;

  typedef enum logic [1:0] {
    OP_SWITCH = 2'd0,
    OP_FREE   = 2'd1,
    OP_IDLE   = 2'd2,
    OP_READ   = 2'd3
  } setr_op_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_READ  = 2'd2
  } setr_kind_e;

  typedef enum logic {
    CFG_CAPTURE_MARGIN = 1'b0,
    CFG_IDLE_MARGIN    = 1'b1
  } setr_cfg_idx_e;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [PID_W-1:0]  pid;
  } setr_key_t;

  typedef struct packed {
    setr_op_e             op;
    logic [TS_W-1:0]      ts;
    logic [PID_W-1:0]     pid;
    logic [PID_W-1:0]     tgid;
    logic [COOKIE_W-1:0]  cookie;
    logic                 run;
    logic                 iow;
    logic [HASH_W-1:0]    hash;
    logic                 ok;
  } setr_item_t;

endpackage

>>> rtl/core/sched_event_trace_recorder_core.sv
// Top level of the scheduler event trace recorder: front end, record logic, result sequencer.
// Depends on setr_pkg and setr_name_cache.
//
// Scheduler events arrive as stream transactions and leave as record word writes, name emit
// requests and read-done reports, one output transaction per cycle unless the output stalls.
// An event moves through two front-end stages (set index, then key row read from the name
// memory) and is decided in the second; the result sequencer then issues its results, one to
// seven, a read one. An event that gives nothing leaves stage two without waiting on the
// sequencer. An accepted event passes the stage-one, stage-two and sequencer registers before
// its first result is offered. After reset a clearing pass zeroes the name memory, one set per
// cycle; the input is not ready meanwhile, configuration writes are still taken.
module sched_event_trace_recorder_core #(
  parameter int unsigned BUF_WORDS = setr_pkg::BUF_WORDS_DEF,
  parameter int unsigned NAME_SETS = setr_pkg::NAME_SETS_DEF,
  parameter int unsigned NAME_WAYS = setr_pkg::NAME_WAYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [setr_pkg::MARGIN_W-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // time_stamp, pid, tgid, cookie, prev_was_running, prev_in_iowait, name_hash,
  // name_space_ok, zero padding
  input  logic [setr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // buffer_sel, address, word, name_pid, count, zero padding
  output logic [setr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned POS_W   = $clog2(BUF_WORDS + 1);
  localparam int unsigned SET_W   = $clog2(NAME_SETS);
  localparam int unsigned PID_W   = setr_pkg::PID_W;
  localparam int unsigned MUL_SH  = PID_W + SET_W;
  localparam int unsigned RECIP_W = PID_W + 1;
  localparam int unsigned MUL_W   = PID_W + RECIP_W;
  localparam int unsigned SUM_W   =
      ((POS_W > setr_pkg::MARGIN_W) ? POS_W : setr_pkg::MARGIN_W) + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << MUL_SH) + 64'(NAME_SETS) - 64'd1) / 64'(NAME_SETS));
  localparam logic [SUM_W-1:0] BUF_SUM = SUM_W'(BUF_WORDS);

  // configuration and trace state
  logic [setr_pkg::MARGIN_W-1:0] cap_margin_q, idle_margin_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             half_q, half_d;
  logic             ovf_q, ovf_d;

  // front end
  setr_pkg::setr_item_t in_item;
  logic                 s_hs;
  logic [MUL_W-1:0]     prod;
  logic                 s1_vld_q;
  setr_pkg::setr_item_t s1_item_q;
  logic [PID_W-1:0]     s1_quot_q;
  logic [SET_W-1:0]     s1_set;
  logic                 s1_move;
  logic                 s2_vld_q;
  setr_pkg::setr_item_t s2_item_q;
  logic [SET_W-1:0]     s2_set_q;
  logic                 s2_take;
  logic                 s2_fire;
  logic                 s2_any;

  // name cache
  logic                 cache_busy;
  logic                 lk_emit;
  logic                 lk_en;
  setr_pkg::setr_key_t  lk_key;

  // stage-two decision
  logic                            dec_rec, dec_name, dec_rd;
  logic [setr_pkg::WORD_W-1:0]     dec_w0, dec_w4;
  logic [PID_W-1:0]                dec_w2, dec_w3;
  logic [1:0]                      dec_w5;
  logic [1:0]                      st_code;
  logic                            room, fit_cap, fit_idle;

  // result sequencer
  logic                            seq_name_q, seq_rd_q;
  logic [2:0]                      seq_left_q;
  logic [PID_W-1:0]                seq_pid_q;
  logic                            seq_sel_q;
  logic [POS_W-1:0]                seq_base_q;
  logic [setr_pkg::WORD_W-1:0]     seq_w0_q, seq_ts_q, seq_w4_q;
  logic [PID_W-1:0]                seq_w2_q, seq_w3_q;
  logic [1:0]                      seq_w5_q;
  logic                            seq_load;
  logic                            seq_free;
  logic                            m_hs;
  logic [2:0]                      idx;

  logic                            o_sel;
  logic [setr_pkg::ADDR_W-1:0]     o_addr;
  logic [setr_pkg::WORD_W-1:0]     o_word;
  logic [PID_W-1:0]                o_npid;
  logic [setr_pkg::COUNT_W-1:0]    o_count;
  setr_pkg::setr_kind_e            o_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_margin_q  <= setr_pkg::CAPTURE_MARGIN_RST;
      idle_margin_q <= setr_pkg::IDLE_MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (setr_pkg::setr_cfg_idx_e'(cfg_idx_i))
        setr_pkg::CFG_CAPTURE_MARGIN: cap_margin_q  <= cfg_wdata_i;
        setr_pkg::CFG_IDLE_MARGIN:    idle_margin_q <= cfg_wdata_i;
      endcase
    end
  end

  assign in_item.op     = setr_pkg::setr_op_e'(s_axis_tuser);
  assign in_item.ts     = s_axis_tdata[setr_pkg::I_TS_LSB +: setr_pkg::TS_W];
  assign in_item.pid    = s_axis_tdata[setr_pkg::I_PID_LSB +: PID_W];
  assign in_item.tgid   = s_axis_tdata[setr_pkg::I_TGID_LSB +: PID_W];
  assign in_item.cookie = s_axis_tdata[setr_pkg::I_COOKIE_LSB +: setr_pkg::COOKIE_W];
  assign in_item.run    = s_axis_tdata[setr_pkg::I_RUN_BIT];
  assign in_item.iow    = s_axis_tdata[setr_pkg::I_IOW_BIT];
  assign in_item.hash   = s_axis_tdata[setr_pkg::I_HASH_LSB +: setr_pkg::HASH_W];
  assign in_item.ok     = s_axis_tdata[setr_pkg::I_OK_BIT];

  assign prod    = MUL_W'(in_item.pid) * MUL_W'(RECIP);
  assign s1_set  = SET_W'(s1_item_q.pid - PID_W'(s1_quot_q * PID_W'(NAME_SETS)));

  assign s2_fire       = s2_vld_q && (seq_free || !s2_any);
  assign s2_take       = !s2_vld_q || s2_fire;
  assign s1_move       = s1_vld_q && s2_take;
  assign s_axis_tready = !cache_busy && (!s1_vld_q || s2_take);
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s_hs) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        s2_vld_q <= 1'b1;
      end else if (s2_fire) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      s1_item_q <= in_item;
      s1_quot_q <= PID_W'(prod >> MUL_SH);
    end
    if (s1_move) begin
      s2_item_q <= s1_item_q;
      s2_set_q  <= s1_set;
    end
  end

  assign lk_key.hash = s2_item_q.hash;
  assign lk_key.pid  = s2_item_q.pid;
  assign lk_en       = s2_fire && (s2_item_q.op == setr_pkg::OP_SWITCH);

  setr_name_cache #(
    .NAME_SETS (NAME_SETS),
    .NAME_WAYS (NAME_WAYS)
  ) u_name_cache (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (cache_busy),
    .rd_en_i    (s1_move),
    .rd_set_i   (s1_set),
    .lk_en_i    (lk_en),
    .lk_set_i   (s2_set_q),
    .lk_key_i   (lk_key),
    .lk_space_i (s2_item_q.ok),
    .lk_emit_o  (lk_emit)
  );

  assign room     = (SUM_W'(pos_q) + SUM_W'(setr_pkg::REC_WORDS)) <= BUF_SUM;
  assign fit_cap  = ((SUM_W'(pos_q) + SUM_W'(cap_margin_q)) < BUF_SUM) && room;
  assign fit_idle = ((SUM_W'(pos_q) + SUM_W'(idle_margin_q)) < BUF_SUM) && room;

  always_comb begin
    priority if (s2_item_q.run) begin
      st_code = setr_pkg::ST_RUNNING;
    end else if (s2_item_q.iow) begin
      st_code = setr_pkg::ST_IOWAIT;
    end else begin
      st_code = setr_pkg::ST_SLEEP;
    end
  end

  always_comb begin
    dec_rec  = 1'b0;
    dec_name = 1'b0;
    dec_rd   = 1'b0;
    dec_w0   = setr_pkg::TYPE_SWITCH;
    dec_w2   = '0;
    dec_w3   = '0;
    dec_w4   = '0;
    dec_w5   = setr_pkg::ST_RUNNING;
    pos_d    = pos_q;
    half_d   = half_q;
    ovf_d    = ovf_q;
    unique case (s2_item_q.op)
      setr_pkg::OP_READ: begin
        dec_rd = 1'b1;
        half_d = !half_q;
        pos_d  = '0;
        ovf_d  = 1'b0;
      end
      setr_pkg::OP_IDLE: begin
        dec_rec = fit_idle;
        dec_w5  = setr_pkg::ST_SLEEP;
      end
      setr_pkg::OP_SWITCH, setr_pkg::OP_FREE: begin
        dec_name = (s2_item_q.op == setr_pkg::OP_SWITCH) && lk_emit;
        if (fit_cap) begin
          dec_rec = 1'b1;
          dec_w2  = s2_item_q.pid;
          dec_w3  = s2_item_q.tgid;
          if (s2_item_q.op == setr_pkg::OP_SWITCH) begin
            dec_w4 = {{32{s2_item_q.cookie[setr_pkg::COOKIE_W-1]}}, s2_item_q.cookie};
            dec_w5 = st_code;
          end else begin
            dec_w0 = setr_pkg::TYPE_FREE;
          end
        end else if (!ovf_q) begin
          ovf_d   = 1'b1;
          dec_rec = room;
          dec_w0  = setr_pkg::TYPE_OVERFLOW;
        end
      end
    endcase
    if (dec_rec) begin
      pos_d = pos_q + POS_W'(setr_pkg::REC_WORDS);
    end
  end

  assign s2_any = dec_rec || dec_name || dec_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      half_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (s2_fire) begin
      pos_q  <= pos_d;
      half_q <= half_d;
      ovf_q  <= ovf_d;
    end
  end

  assign m_axis_tvalid = seq_name_q || seq_rd_q || (seq_left_q != 3'd0);
  assign m_hs          = m_axis_tvalid && m_axis_tready;
  assign seq_free      = !m_axis_tvalid || (m_hs && m_axis_tlast);
  assign seq_load      = s2_fire && s2_any;
  assign m_axis_tlast  = seq_rd_q || (seq_name_q && (seq_left_q == 3'd0)) ||
                         (!seq_name_q && (seq_left_q == 3'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_name_q <= 1'b0;
      seq_rd_q   <= 1'b0;
      seq_left_q <= 3'd0;
    end else if (seq_load) begin
      seq_name_q <= dec_name;
      seq_rd_q   <= dec_rd;
      seq_left_q <= dec_rec ? setr_pkg::REC_WORDS : 3'd0;
    end else if (m_hs) begin
      priority if (seq_name_q) begin
        seq_name_q <= 1'b0;
      end else if (seq_rd_q) begin
        seq_rd_q <= 1'b0;
      end else begin
        seq_left_q <= seq_left_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      seq_pid_q  <= s2_item_q.pid;
      seq_sel_q  <= half_q;
      seq_base_q <= pos_q;
      seq_w0_q   <= dec_w0;
      seq_ts_q   <= s2_item_q.ts;
      seq_w2_q   <= dec_w2;
      seq_w3_q   <= dec_w3;
      seq_w4_q   <= dec_w4;
      seq_w5_q   <= dec_w5;
    end
  end

  assign idx = setr_pkg::REC_WORDS - seq_left_q;

  always_comb begin
    o_kind  = setr_pkg::KIND_WRITE;
    o_sel   = 1'b0;
    o_addr  = '0;
    o_word  = '0;
    o_npid  = '0;
    o_count = '0;
    priority if (seq_name_q) begin
      o_kind = setr_pkg::KIND_NAME;
      o_npid = seq_pid_q;
    end else if (seq_rd_q) begin
      o_kind  = setr_pkg::KIND_READ;
      o_sel   = seq_sel_q;
      o_count = setr_pkg::COUNT_W'(seq_base_q);
    end else begin
      o_sel  = seq_sel_q;
      o_addr = setr_pkg::ADDR_W'(seq_base_q + POS_W'(idx));
      unique case (idx)
        3'd0:    o_word = seq_w0_q;
        3'd1:    o_word = seq_ts_q;
        3'd2:    o_word = setr_pkg::WORD_W'(seq_w2_q);
        3'd3:    o_word = setr_pkg::WORD_W'(seq_w3_q);
        3'd4:    o_word = seq_w4_q;
        3'd5:    o_word = setr_pkg::WORD_W'(seq_w5_q);
        default: o_word = '0;
      endcase
    end
  end

  assign m_axis_tuser = o_kind;
  assign m_axis_tdata = {{setr_pkg::O_PAD_W{1'b0}}, o_count, o_npid, o_word, o_addr, o_sel};

endmodule

>>> rtl/core/setr_name_cache.sv
// Set-associative store of name keys: one memory row per set, read-modify-write.
// Depends on setr_pkg; holds the clearing pass after reset and write forwarding.
module setr_name_cache #(
  parameter int unsigned NAME_SETS = setr_pkg::NAME_SETS_DEF,
  parameter int unsigned NAME_WAYS = setr_pkg::NAME_WAYS_DEF,
  localparam int unsigned SET_W = $clog2(NAME_SETS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               busy_o,
  input  logic               rd_en_i,
  input  logic [SET_W-1:0]   rd_set_i,
  input  logic               lk_en_i,
  input  logic [SET_W-1:0]   lk_set_i,
  input  setr_pkg::setr_key_t lk_key_i,
  input  logic               lk_space_i,
  output logic               lk_emit_o
);

  setr_pkg::setr_key_t [NAME_WAYS-1:0] key_mem [NAME_SETS];
  setr_pkg::setr_key_t [NAME_WAYS-1:0] rd_row_q;
  setr_pkg::setr_key_t [NAME_WAYS-1:0] fwd_row_q;
  setr_pkg::setr_key_t [NAME_WAYS-1:0] cur_row;
  setr_pkg::setr_key_t [NAME_WAYS-1:0] new_row;
  setr_pkg::setr_key_t [NAME_WAYS-1:0] wr_row;
  logic [SET_W-1:0] fwd_set_q;
  logic             fwd_vld_q;
  logic             clr_q;
  logic [SET_W-1:0] clr_idx_q;
  logic             hit;
  logic             lk_wr;
  logic             wr_en;
  logic [SET_W-1:0] wr_set;

  assign busy_o = clr_q;
  assign cur_row = (fwd_vld_q && (fwd_set_q == lk_set_i)) ? fwd_row_q : rd_row_q;

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < NAME_WAYS; w++) begin
      if (cur_row[w] == lk_key_i) begin
        hit = 1'b1;
      end
    end
    new_row[0] = lk_key_i;
    for (int w = 1; w < NAME_WAYS; w++) begin
      new_row[w] = cur_row[w-1];
    end
  end

  assign lk_emit_o = !hit && lk_space_i;
  assign lk_wr     = lk_en_i && lk_emit_o;
  assign wr_en     = clr_q || lk_wr;
  assign wr_set    = clr_q ? clr_idx_q : lk_set_i;
  assign wr_row    = clr_q ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_set] <= wr_row;
    end
    if (rd_en_i) begin
      rd_row_q <= key_mem[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      fwd_vld_q <= 1'b0;
    end else if (clr_q) begin
      fwd_vld_q <= 1'b0;
      clr_idx_q <= clr_idx_q + SET_W'(1);
      if (clr_idx_q == SET_W'(NAME_SETS - 1)) begin
        clr_q <= 1'b0;
      end
    end else if (lk_wr) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_wr && !clr_q) begin
      fwd_set_q <= lk_set_i;
      fwd_row_q <= new_row;
    end
  end

endmodule

>>> rtl/core/setr_checker.sv
// Port-level checks of the scheduler event trace recorder, attached by bind.
// Depends on setr_pkg and on the port list of sched_event_trace_recorder_core.
module setr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [setr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);

  logic [setr_pkg::ADDR_W-1:0]  addr;
  logic [setr_pkg::WORD_W-1:0]  word;
  logic [setr_pkg::PID_W-1:0]   npid;
  logic [setr_pkg::COUNT_W-1:0] count;

  assign addr  = m_axis_tdata[setr_pkg::O_ADDR_LSB +: setr_pkg::ADDR_W];
  assign word  = m_axis_tdata[setr_pkg::O_WORD_LSB +: setr_pkg::WORD_W];
  assign npid  = m_axis_tdata[setr_pkg::O_NPID_LSB +: setr_pkg::PID_W];
  assign count = m_axis_tdata[setr_pkg::O_COUNT_LSB +: setr_pkg::COUNT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == setr_pkg::KIND_READ) |->
      m_axis_tlast && (word == '0) && (npid == '0) && (addr == '0))
    else $error("read report malformed");

  a_name_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == setr_pkg::KIND_NAME) |->
      !m_axis_tdata[setr_pkg::O_SEL_BIT] && (addr == '0) && (word == '0) && (count == '0))
    else $error("name emit carries record fields");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready && !m_axis_tvalid)
    else $error("activity straight after reset");

endmodule

bind sched_event_trace_recorder_core setr_checker u_setr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sched_event_trace_recorder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of sched_event_trace_recorder_core: stream events in, compare every
// output transaction against a built-in predictor of records, name emits and read reports.
// Depends on setr_pkg and the recorder RTL only.
module sched_event_trace_recorder_core_tb;
  import setr_pkg::*;

  localparam int unsigned BUF_N         = BUF_WORDS_DEF;
  localparam int unsigned SETS          = NAME_SETS_DEF;
  localparam int unsigned WAYS          = NAME_WAYS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RAND_ITEMS    = 110;
  localparam int unsigned ZERO_ITEMS    = 16;

  typedef struct {
    setr_kind_e         kind;
    logic               sel;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  word;
    logic [PID_W-1:0]   npid;
    logic [COUNT_W-1:0] count;
    logic               last;
  } trace_res_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_idx_i     = 1'b0;
  logic [MARGIN_W-1:0]    cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  sched_event_trace_recorder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [COUNT_W-1:0]  fill_pos   = '0;
  logic                cur_half   = 1'b0;
  logic                ovf_seen   = 1'b0;
  logic [MARGIN_W-1:0] cap_margin = CAPTURE_MARGIN_RST;
  logic [MARGIN_W-1:0] idle_gap   = IDLE_MARGIN_RST;
  logic [WORD_W-1:0]   key_store [SETS*WAYS];
  trace_res_t          trace_due_q [$];

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_cnt        = 0;
  int unsigned events_sent    = 0;
  int unsigned n_writes       = 0;
  int unsigned n_names        = 0;
  int unsigned n_reads        = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               trace_due_q.size());
      $display("sched_event_trace_recorder_core_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("mismatch in %s at cycle %0d: expected %0h, got %0h", what, cycle_cnt, exp_v, got_v);
    err_cnt++;
  endtask

  function automatic void push_res(input setr_kind_e kind, input logic sel,
                                   input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] word,
                                   input logic [PID_W-1:0] npid, input logic [COUNT_W-1:0] count);
    trace_res_t r;
    r.kind  = kind;
    r.sel   = sel;
    r.addr  = addr;
    r.word  = word;
    r.npid  = npid;
    r.count = count;
    r.last  = 1'b0;
    trace_due_q.push_back(r);
  endfunction

  function automatic bit has_room(input logic [MARGIN_W-1:0] margin);
    return (int'(fill_pos) + int'(margin) < int'(BUF_N)) && (int'(fill_pos) + 6 <= int'(BUF_N));
  endfunction

  function automatic void put_record(input logic [5:0][WORD_W-1:0] rec);
    for (int i = 0; i < 6; i++) begin
      push_res(KIND_WRITE, cur_half, fill_pos[ADDR_W-1:0], rec[i], '0, '0);
      fill_pos++;
    end
  endfunction

  function automatic int name_check(input logic [PID_W-1:0] pid, input logic [HASH_W-1:0] hash,
                                    input logic ok);
    logic [WORD_W-1:0] key;
    int unsigned base;
    key  = {hash, 10'b0, pid};
    base = (int'(pid) % SETS) * WAYS;
    for (int x = 0; x < WAYS; x++) begin
      if (key_store[base+x] == key) return 0;
    end
    if (!ok) return 0;
    for (int x = WAYS - 1; x > 0; x--) key_store[base+x] = key_store[base+x-1];
    key_store[base] = key;
    push_res(KIND_NAME, 1'b0, '0, '0, pid, '0);
    return 1;
  endfunction

  function automatic void record_event(input setr_item_t it);
    int k;
    logic [5:0][WORD_W-1:0] rec;
    logic [WORD_W-1:0] ck_ext;
    logic [1:0] st;
    trace_res_t tail;
    k = 0;
    case (it.op)
      OP_READ: begin
        push_res(KIND_READ, cur_half, '0, '0, '0, fill_pos);
        k = 1;
        cur_half = ~cur_half;
        fill_pos = '0;
        ovf_seen = 1'b0;
      end
      OP_IDLE: begin
        if (has_room(idle_gap)) begin
          rec    = '0;
          rec[0] = TYPE_SWITCH;
          rec[1] = it.ts;
          rec[5] = 64'(ST_SLEEP);
          put_record(rec);
          k = 6;
        end
      end
      default: begin
        ck_ext = '0;
        st     = ST_RUNNING;
        if (it.op == OP_SWITCH) begin
          ck_ext = {{32{it.cookie[31]}}, it.cookie};
          k += name_check(it.pid, it.hash, it.ok);
          st = it.run ? ST_RUNNING : (it.iow ? ST_IOWAIT : ST_SLEEP);
        end
        if (has_room(cap_margin)) begin
          rec[0] = (it.op == OP_SWITCH) ? TYPE_SWITCH : TYPE_FREE;
          rec[1] = it.ts;
          rec[2] = 64'(it.pid);
          rec[3] = 64'(it.tgid);
          rec[4] = ck_ext;
          rec[5] = 64'(st);
          put_record(rec);
          k += 6;
        end else if (!ovf_seen) begin
          ovf_seen = 1'b1;
          if (int'(fill_pos) + 6 <= int'(BUF_N)) begin
            rec    = '0;
            rec[0] = TYPE_OVERFLOW;
            rec[1] = it.ts;
            put_record(rec);
            k += 6;
          end
        end
      end
    endcase
    if (k > 0) begin
      tail      = trace_due_q.pop_back();
      tail.last = 1'b1;
      trace_due_q.push_back(tail);
    end
  endfunction

  task automatic check_result();
    trace_res_t         exp_r;
    logic [1:0]         g_kind;
    logic               g_sel;
    logic [ADDR_W-1:0]  g_addr;
    logic [WORD_W-1:0]  g_word;
    logic [PID_W-1:0]   g_npid;
    logic [COUNT_W-1:0] g_count;
    g_kind  = m_axis_tuser;
    g_sel   = m_axis_tdata[O_SEL_BIT];
    g_addr  = m_axis_tdata[O_ADDR_LSB +: ADDR_W];
    g_word  = m_axis_tdata[O_WORD_LSB +: WORD_W];
    g_npid  = m_axis_tdata[O_NPID_LSB +: PID_W];
    g_count = m_axis_tdata[O_COUNT_LSB +: COUNT_W];
    case (g_kind)
      KIND_WRITE: n_writes++;
      KIND_NAME:  n_names++;
      default:    n_reads++;
    endcase
    if (trace_due_q.size() == 0) begin
      report_mismatch("result with nothing pending (word)", '0, g_word);
      return;
    end
    exp_r = trace_due_q.pop_front();
    if (g_kind !== exp_r.kind) report_mismatch("kind", 64'(exp_r.kind), 64'(g_kind));
    if (g_sel !== exp_r.sel) report_mismatch("buffer_sel", 64'(exp_r.sel), 64'(g_sel));
    if (g_addr !== exp_r.addr) report_mismatch("address", 64'(exp_r.addr), 64'(g_addr));
    if (g_word !== exp_r.word) report_mismatch("word", exp_r.word, g_word);
    if (g_npid !== exp_r.npid) report_mismatch("name_pid", 64'(exp_r.npid), 64'(g_npid));
    if (g_count !== exp_r.count) report_mismatch("count", 64'(exp_r.count), 64'(g_count));
    if (m_axis_tlast !== exp_r.last) report_mismatch("last", 64'(exp_r.last), 64'(m_axis_tlast));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  function automatic setr_item_t mk_event(input setr_op_e op, input logic [TS_W-1:0] ts,
                                          input logic [PID_W-1:0] pid,
                                          input logic [PID_W-1:0] tgid,
                                          input logic [COOKIE_W-1:0] cookie, input logic run,
                                          input logic iow, input logic [HASH_W-1:0] hash,
                                          input logic ok);
    setr_item_t it;
    it.op     = op;
    it.ts     = ts;
    it.pid    = pid;
    it.tgid   = tgid;
    it.cookie = cookie;
    it.run    = run;
    it.iow    = iow;
    it.hash   = hash;
    it.ok     = ok;
    return it;
  endfunction

  // pids and hashes mostly from a small pool so that sets collide, hit and evict
  function automatic setr_item_t rand_event(input bit allow_read);
    setr_item_t it;
    int unsigned r;
    r = allow_read ? $urandom_range(99) : $urandom_range(84);
    it.op = (r < 45) ? OP_SWITCH : (r < 65) ? OP_FREE : (r < 85) ? OP_IDLE : OP_READ;
    it.ts = {$urandom, $urandom};
    if ($urandom_range(99) < 70) begin
      it.pid  = 22'($urandom_range(3) * 256 + $urandom_range(5));
      it.hash = 32'($urandom_range(2));
    end else begin
      it.pid  = 22'($urandom);
      it.hash = $urandom;
    end
    it.tgid   = 22'($urandom);
    it.cookie = $urandom;
    it.run    = 1'($urandom_range(1));
    it.iow    = 1'($urandom_range(1));
    it.ok     = ($urandom_range(99) < 85);
    return it;
  endfunction

  // entered and left just after a falling edge
  task automatic send_event(input setr_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.ok, it.hash, it.iow, it.run, it.cookie, it.tgid, it.pid, it.ts};
    s_axis_tuser  <= it.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    record_event(it);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (trace_due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_margins(input logic [MARGIN_W-1:0] cap, input logic [MARGIN_W-1:0] idle);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CAPTURE_MARGIN;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IDLE_MARGIN;
    cfg_wdata_i <= idle;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_margin = cap;
    idle_gap   = idle;
  endtask

  task automatic test_name_cache_and_records();
    send_event(mk_event(OP_SWITCH, '1, '0, '0, 32'h8000_0000, 1'b1, 1'b0, '0, 1'b1));
    send_event(mk_event(OP_SWITCH, '0, '1, '1, 32'h7FFF_FFFF, 1'b0, 1'b1, '1, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h5A5A, '1, '1, 32'h7FFF_FFFF, 1'b0, 1'b1, '1, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h10, 22'd5, 22'd5, '1, 1'b0, 1'b0, 32'd7, 1'b0));
    send_event(mk_event(OP_SWITCH, 64'h11, 22'd5, 22'd5, '1, 1'b0, 1'b0, 32'd7, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h12, 22'd261, 22'd9, 32'd3, 1'b1, 1'b1, 32'd9, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h13, 22'd517, 22'd1, 32'd4, 1'b0, 1'b1, 32'd1, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h14, 22'd5, 22'd5, '0, 1'b1, 1'b0, 32'd7, 1'b1));
    send_event(mk_event(OP_FREE, 64'h15, 22'd1234, 22'd77, 32'hDEAD_BEEF, 1'b1, 1'b1,
                        32'h1234, 1'b1));
    send_event(mk_event(OP_IDLE, {$urandom, $urandom}, 22'd8, 22'd8, '1, 1'b0, 1'b0, '1, 1'b0));
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_READ, '1, '1, '1, '1, 1'b1, 1'b1, '1, 1'b1));
    drain();
  endtask

  task automatic test_overflow_and_margins();
    set_margins(14'd8192, 14'd48);
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_SWITCH, 64'h21, 22'd99, 22'd1, 32'd5, 1'b1, 1'b0, 32'd3, 1'b1));
    send_event(mk_event(OP_SWITCH, 64'h22, 22'd100, 22'd2, 32'd6, 1'b0, 1'b0, 32'd4, 1'b1));
    send_event(mk_event(OP_FREE, 64'h23, 22'd101, 22'd3, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_IDLE, 64'h24, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    drain();
    set_margins(14'd8192, 14'd8192);
    send_event(mk_event(OP_IDLE, 64'h31, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_FREE, 64'h32, 22'd7, 22'd7, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    drain();
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct,
                                   input logic [MARGIN_W-1:0] cap,
                                   input logic [MARGIN_W-1:0] idle);
    set_margins(cap, idle);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (RAND_ITEMS) send_event(rand_event(1'b1));
    drain();
  endtask

  // zero margins: every event that fits is captured, read reports the fill
  task automatic test_zero_margins();
    set_margins(14'd0, 14'd0);
    src_idle_pct   = 0;
    sink_stall_pct = 8;
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    repeat (ZERO_ITEMS) send_event(rand_event(1'b0));
    send_event(mk_event(OP_SWITCH, 64'h41, 22'd3, 22'd3, '1, 1'b0, 1'b1, 32'd11, 1'b1));
    send_event(mk_event(OP_IDLE, 64'h42, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_FREE, 64'h43, 22'd4, 22'd4, '0, 1'b0, 1'b0, '0, 1'b0));
    send_event(mk_event(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    drain();
  endtask

  initial begin
    for (int i = 0; i < SETS * WAYS; i++) key_store[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_name_cache_and_records();
    test_overflow_and_margins();
    test_random_phase(0, 0, 14'($urandom_range(200)), 14'($urandom_range(200)));
    test_random_phase(56, 0, 14'($urandom_range(8000, 8191)), 14'($urandom_range(8000, 8192)));
    test_random_phase(0, 56, 14'd8191, 14'd0);
    test_random_phase(8, 8, 14'($urandom_range(7800, 8192)), 14'($urandom_range(7800, 8192)));
    test_zero_margins();
    $display("covered %0d events: %0d record words, %0d name emits, %0d read reports checked",
             events_sent, n_writes, n_names, n_reads);
    $display("margins swept from 0 to 8192 under source idling and sink stalls, %0d mismatches",
             err_cnt);
    if (err_cnt == 0) begin
      $display("sched_event_trace_recorder_core_tb OK");
    end else begin
      $display("sched_event_trace_recorder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
